// ===== rtl/core/rdbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdbc_pkg
// Types and constants shared by the ROM DMA buffer cache.
// ----------------------------------------------------------------------------
package rdbc_pkg;

    localparam int NUM_BUFFERS_DEF = 32;
    localparam int MAX_BUFFERS     = 64;

    localparam logic [7:0]  DRIVE_SEL       = 8'hFF;
    localparam logic [31:0] DRIVE_BASE      = 32'h0014_0000;
    localparam logic [6:0]  DMA_COUNT_MAX   = 7'd127;
    localparam logic [16:0] BUF_BYTES_RESET = 17'd1024;

    // configuration register indexes
    localparam logic CFG_BUFFER_BYTES = 1'b0;
    localparam logic CFG_CART_BYPASS  = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_PASS      = 3'd2,
        ST_NO_BUFFER = 3'd3,
        ST_TICK_DONE = 3'd4
    } t_status;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_TICK   = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [31:0] rom_address;
        logic [16:0] request_length;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [5:0]  entry_index;
        logic [16:0] byte_offset;
        logic [31:0] dma_device_address;
        logic        dma_from_drive;
        logic [5:0]  dma_slot;
    } t_rsp;

endpackage

// ===== rtl/core/rdbc_hit_sel.sv =====
// ----------------------------------------------------------------------------
// rdbc_hit_sel
// Picks the covering buffer with the lowest start; ties go to the lower index.
// ----------------------------------------------------------------------------
module rdbc_hit_sel #(
    parameter int NUM_BUFFERS = rdbc_pkg::NUM_BUFFERS_DEF,
    parameter int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1
) (
    input  logic [NUM_BUFFERS-1:0] i_cover,
    input  logic [31:0]            i_start [NUM_BUFFERS],
    output logic                   o_hit,
    output logic [IDX_W-1:0]       o_idx
);

    localparam int P = 1 << IDX_W;

    // binary tree, node n has children 2n+1 and 2n+2, leaves from P-1
    logic [2*P-2:0]   v;
    logic [31:0]      s  [2*P-1];
    logic [IDX_W-1:0] ix [2*P-1];

    genvar k, n;
    generate
        for (k = 0; k < P; k++) begin : g_leaf
            if (k < NUM_BUFFERS) begin : g_real
                assign v[P-1+k]  = i_cover[k];
                assign s[P-1+k]  = i_start[k];
            end else begin : g_pad
                assign v[P-1+k]  = 1'b0;
                assign s[P-1+k]  = 32'd0;
            end
            assign ix[P-1+k] = IDX_W'(k);
        end
        for (n = 0; n < P-1; n++) begin : g_node
            logic pick_l;
            // left holds the lower indexes, so it wins on equal start
            assign pick_l = v[2*n+1] && (!v[2*n+2] || (s[2*n+1] <= s[2*n+2]));
            assign v[n]   = v[2*n+1] | v[2*n+2];
            assign s[n]   = pick_l ? s[2*n+1]  : s[2*n+2];
            assign ix[n]  = pick_l ? ix[2*n+1] : ix[2*n+2];
        end
    endgenerate

    assign o_hit = v[0];
    assign o_idx = ix[0];

endmodule

// ===== rtl/core/rom_dma_buffer_cache.sv =====
// ----------------------------------------------------------------------------
// rom_dma_buffer_cache
// Caches ROM sample data in a pool of equal-sized buffers and issues DMA
// requests on misses; frame ticks age out unused buffers.
// ----------------------------------------------------------------------------
// One request or frame tick is taken every clock cycle (o_busy stays low).
// A beat accepted on i_start is registered and looked up against all buffers
// in parallel; its result is registered and strobed on o_done in the cycle
// after the lookup, throughput one per cycle, each request seeing the buffer
// state left by the one before it. The result is shown for one cycle only
// and cannot be held off, so the receiver must take every o_done beat.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while no request is in flight (not enforced here).
// ----------------------------------------------------------------------------
module rom_dma_buffer_cache #(
    parameter int NUM_BUFFERS = rdbc_pkg::NUM_BUFFERS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  rdbc_pkg::t_req i_req,
    output logic           o_done,
    output rdbc_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [16:0]    i_cfg_data
);

    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    // control
    logic                   r_req_vld;
    logic                   r_rsp_vld;
    logic [NUM_BUFFERS-1:0] r_active, n_active;
    logic [31:0]            r_frame, n_frame;
    logic [6:0]             r_dma_cnt, n_dma_cnt;
    logic [16:0]            r_buf_bytes;
    logic                   r_bypass;

    // payload
    rdbc_pkg::t_req         r_req;
    rdbc_pkg::t_rsp         r_rsp, n_rsp;
    logic [31:0]            r_start [NUM_BUFFERS];
    logic [31:0]            r_last  [NUM_BUFFERS];

    logic                   drive;
    logic [31:0]            addr;
    logic [32:0]            need_end;
    logic [NUM_BUFFERS-1:0] in_range;
    logic [NUM_BUFFERS-1:0] aged;
    logic                   hit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   free_ok;
    logic [IDX_W-1:0]       free_idx;
    logic [31:0]            miss_start;
    logic                   start_we, last_we;
    logic [IDX_W-1:0]       wr_idx;
    logic [31:0]            hit_off;

    assign o_busy = 1'b0;
    assign o_done = r_rsp_vld;
    assign o_rsp  = r_rsp;

    // address remap
    always_comb begin
        drive = (r_req.rom_address[31:24] == rdbc_pkg::DRIVE_SEL);
        if (drive) begin
            addr = {8'd0, r_req.rom_address[23:0]} + rdbc_pkg::DRIVE_BASE;
        end else begin
            addr = r_req.rom_address;
        end
        need_end   = {1'b0, addr} + {16'd0, r_req.request_length};
        miss_start = {addr[31:1], 1'b0};
    end

    // per-buffer coverage and aging
    always_comb begin
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            in_range[i] = r_active[i] && (r_start[i] <= addr) &&
                          (({1'b0, r_start[i]} + {16'd0, r_buf_bytes}) >= need_end);
            aged[i]     = r_active[i] && ((r_last[i] + 32'd1) < r_frame);
        end
    end

    // lowest free buffer
    always_comb begin
        free_ok  = ~&r_active;
        free_idx = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    rdbc_hit_sel #(
        .NUM_BUFFERS (NUM_BUFFERS),
        .IDX_W       (IDX_W)
    ) u_hit_sel (
        .i_cover (in_range),
        .i_start (r_start),
        .o_hit   (hit),
        .o_idx   (hit_idx)
    );

    assign hit_off = addr - r_start[hit_idx];

    always_comb begin
        n_active  = r_active;
        n_frame   = r_frame;
        n_dma_cnt = r_dma_cnt;
        n_rsp     = '0;
        start_we  = 1'b0;
        last_we   = 1'b0;
        wr_idx    = hit ? hit_idx : free_idx;
        if (r_req.req_type == rdbc_pkg::REQ_TICK) begin
            n_active     = r_active & ~aged;
            n_dma_cnt    = '0;
            n_frame      = r_frame + 32'd1;
            n_rsp.status = rdbc_pkg::ST_TICK_DONE;
        end else if (!drive && r_bypass) begin
            n_rsp.status             = rdbc_pkg::ST_PASS;
            n_rsp.dma_device_address = r_req.rom_address;
        end else if (hit) begin
            last_we           = 1'b1;
            n_rsp.status      = rdbc_pkg::ST_HIT;
            n_rsp.entry_index = 6'(hit_idx);
            n_rsp.byte_offset = hit_off[16:0];
        end else if (!free_ok) begin
            n_rsp.status = rdbc_pkg::ST_NO_BUFFER;
        end else begin
            start_we                 = 1'b1;
            last_we                  = 1'b1;
            n_active[free_idx]       = 1'b1;
            if (r_dma_cnt < rdbc_pkg::DMA_COUNT_MAX) begin
                n_dma_cnt = r_dma_cnt + 7'd1;
            end
            n_rsp.status             = rdbc_pkg::ST_MISS;
            n_rsp.entry_index        = 6'(free_idx);
            n_rsp.byte_offset        = {16'd0, addr[0]};
            n_rsp.dma_device_address = miss_start;
            n_rsp.dma_from_drive     = drive;
            n_rsp.dma_slot           = r_dma_cnt[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld   <= 1'b0;
            r_rsp_vld   <= 1'b0;
            r_active    <= '0;
            r_frame     <= '0;
            r_dma_cnt   <= '0;
            r_buf_bytes <= rdbc_pkg::BUF_BYTES_RESET;
            r_bypass    <= 1'b0;
        end else begin
            r_req_vld <= i_start;
            r_rsp_vld <= r_req_vld;
            if (r_req_vld) begin
                r_active  <= n_active;
                r_frame   <= n_frame;
                r_dma_cnt <= n_dma_cnt;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rdbc_pkg::CFG_BUFFER_BYTES: r_buf_bytes <= i_cfg_data;
                    rdbc_pkg::CFG_CART_BYPASS:  r_bypass    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_req <= i_req;
        end
        r_rsp <= n_rsp;
        if (r_req_vld && start_we) begin
            r_start[wr_idx] <= miss_start;
        end
        if (r_req_vld && last_we) begin
            r_last[wr_idx] <= r_frame;
        end
    end

endmodule
